// ===== rtl/ndcg_pkg.sv =====
`timescale 1ns / 1ps

package ndcg_pkg;

    // Store geometry and field widths.
    localparam int NUM_DOCS  = 256;
    localparam int DOC_AW    = 8;
    localparam int CNT_W     = 9;
    localparam int MAX_GRADE = 15;
    localparam int GRADE_W   = 4;
    localparam int SCORE_W   = 32;
    localparam int DISC_W    = 17;
    localparam int GAIN_W    = 15;
    localparam int TERM_W    = 32;
    localparam int DCG_W     = 40;
    localparam int PAIR_W    = 33;
    localparam int REM_W     = 41;
    localparam int QUO_W     = 16;
    localparam int VAL_W     = 18;
    localparam int DIV_STEPS = 16;
    localparam int STEP_W    = 4;

    // Operation codes of the input word.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_DELTA = 1'b1;

    // Result kinds.
    localparam logic KIND_NDCG  = 1'b0;
    localparam logic KIND_DELTA = 1'b1;

    typedef enum logic [1:0] {
        ADR_I,
        ADR_J,
        ADR_A,
        ADR_B
    } adr_sel_t;

    typedef enum logic [1:0] {
        SRC_AA,
        SRC_BB,
        SRC_AB,
        SRC_BA
    } mul_src_t;

    typedef enum logic [1:0] {
        TGT_IDEAL,
        TGT_DCG,
        TGT_NEG,
        TGT_POS
    } acc_tgt_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RK_RD,
        ST_RK_KEY,
        ST_RK_SWEEP,
        ST_RK_DRAIN,
        ST_RK_WRITE,
        ST_ID_INIT,
        ST_ID_RUN,
        ST_ID_DRAIN,
        ST_DC_RUN,
        ST_DC_DRAIN1,
        ST_DC_DRAIN2,
        ST_DL_RA,
        ST_DL_RB,
        ST_DL_LB,
        ST_DL_M1,
        ST_DL_M2,
        ST_DL_M3,
        ST_DL_M4,
        ST_DL_DRAIN,
        ST_DL_DIFF,
        ST_DIV_SETUP,
        ST_DIV_RUN,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     accept;
        logic     close_init;
        adr_sel_t addr_sel;
        logic     rk_clr;
        logic     key_ld;
        logic     sweep;
        logic     rank_wr;
        logic     id_init;
        logic     id_step;
        logic     dc_init;
        logic     dc_step;
        logic     lat_a;
        logic     lat_b;
        logic     mul_en;
        mul_src_t mul_src;
        acc_tgt_t mul_tgt;
        logic     mag_ld;
        logic     div_setup;
        logic     div_step;
        logic     emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic early_err;
        logic j_last;
        logic i_last;
        logic hist_more;
        logic g_zero;
        logic div_last;
    } stat_t;

    typedef logic [DISC_W-1:0] disc_tab_t [NUM_DOCS];

    // Discount 2^16 / log2(rank + 2), rounded, from a 24-bit fractional log.
    function automatic logic [DISC_W-1:0] disc_calc(input int unsigned rank);
        logic [63:0] n;
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] l;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] quo;
        int unsigned k;
        n = 64'(rank) + 64'd2;
        k = 0;
        frac = '0;
        for (int s = 1; s < 32; s++)
        begin
            if ((n >> s) != 64'd0)
            begin
                k = s;
            end
        end
        m = n << (30 - k);
        for (int b = 0; b < 24; b++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                frac = frac | 64'd1;
            end
        end
        l = (64'(k) << 24) | frac;
        num = (64'd1 << 40) + (l >> 1);
        rem = '0;
        quo = '0;
        for (int b = 41; b >= 0; b--)
        begin
            rem = (rem << 1) | 64'(num[b]);
            quo = quo << 1;
            if (rem >= l)
            begin
                rem = rem - l;
                quo = quo | 64'd1;
            end
        end
        return quo[DISC_W-1:0];
    endfunction

    function automatic disc_tab_t disc_table_build();
        disc_tab_t t;
        for (int i = 0; i < NUM_DOCS; i++)
        begin
            t[i] = disc_calc(i);
        end
        return t;
    endfunction

    localparam disc_tab_t DISC_TAB = disc_table_build();

endpackage

// ===== rtl/ndcg_ctrl.sv =====
`timescale 1ns / 1ps

module ndcg_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           op,
    input  logic           last_doc,
    input  ndcg_pkg::stat_t stat,
    output ndcg_pkg::cmd_t  cmd,
    output logic           busy
);
    import ndcg_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_LOAD)
                    begin
                        if (last_doc)
                        begin
                            state_next = ST_RK_RD;
                        end
                    end
                    else if (stat.early_err)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_DL_RA;
                    end
                end
            end
            ST_RK_RD:     state_next = ST_RK_KEY;
            ST_RK_KEY,
            ST_RK_SWEEP:  state_next = stat.j_last ? ST_RK_DRAIN : ST_RK_SWEEP;
            ST_RK_DRAIN:  state_next = ST_RK_WRITE;
            ST_RK_WRITE:  state_next = stat.i_last ? ST_ID_INIT : ST_RK_RD;
            ST_ID_INIT:   state_next = ST_ID_RUN;
            ST_ID_RUN:
            begin
                if (!stat.hist_more && stat.g_zero)
                begin
                    state_next = ST_ID_DRAIN;
                end
            end
            ST_ID_DRAIN:  state_next = ST_DC_RUN;
            ST_DC_RUN:    state_next = stat.i_last ? ST_DC_DRAIN1 : ST_DC_RUN;
            ST_DC_DRAIN1: state_next = ST_DC_DRAIN2;
            ST_DC_DRAIN2: state_next = ST_DIV_SETUP;
            ST_DL_RA:     state_next = ST_DL_RB;
            ST_DL_RB:     state_next = ST_DL_LB;
            ST_DL_LB:     state_next = ST_DL_M1;
            ST_DL_M1:     state_next = ST_DL_M2;
            ST_DL_M2:     state_next = ST_DL_M3;
            ST_DL_M3:     state_next = ST_DL_M4;
            ST_DL_M4:     state_next = ST_DL_DRAIN;
            ST_DL_DRAIN:  state_next = ST_DL_DIFF;
            ST_DL_DIFF:   state_next = ST_DIV_SETUP;
            ST_DIV_SETUP: state_next = ST_DIV_RUN;
            ST_DIV_RUN:   state_next = stat.div_last ? ST_FINISH : ST_DIV_RUN;
            ST_FINISH:    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept     = start;
                cmd.close_init = start && (op == OP_LOAD) && last_doc;
            end
            ST_RK_RD:
            begin
                cmd.addr_sel = ADR_I;
                cmd.rk_clr   = 1'b1;
            end
            ST_RK_KEY:
            begin
                cmd.addr_sel = ADR_J;
                cmd.key_ld   = 1'b1;
                cmd.sweep    = 1'b1;
            end
            ST_RK_SWEEP:
            begin
                cmd.addr_sel = ADR_J;
                cmd.sweep    = 1'b1;
            end
            ST_RK_WRITE:  cmd.rank_wr = 1'b1;
            ST_ID_INIT:   cmd.id_init = 1'b1;
            ST_ID_RUN:    cmd.id_step = 1'b1;
            ST_ID_DRAIN:  cmd.dc_init = 1'b1;
            ST_DC_RUN:
            begin
                cmd.addr_sel = ADR_I;
                cmd.dc_step  = 1'b1;
            end
            ST_DL_RA:     cmd.addr_sel = ADR_A;
            ST_DL_RB:
            begin
                cmd.addr_sel = ADR_B;
                cmd.lat_a    = 1'b1;
            end
            ST_DL_LB:     cmd.lat_b = 1'b1;
            ST_DL_M1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = SRC_AA;
                cmd.mul_tgt = TGT_NEG;
            end
            ST_DL_M2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = SRC_BB;
                cmd.mul_tgt = TGT_NEG;
            end
            ST_DL_M3:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = SRC_AB;
                cmd.mul_tgt = TGT_POS;
            end
            ST_DL_M4:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = SRC_BA;
                cmd.mul_tgt = TGT_POS;
            end
            ST_DL_DIFF:   cmd.mag_ld = 1'b1;
            ST_DIV_SETUP: cmd.div_setup = 1'b1;
            ST_DIV_RUN:   cmd.div_step = 1'b1;
            ST_FINISH:    cmd.emit = 1'b1;
            default:      cmd = '0;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== rtl/ndcg_dp.sv =====
`timescale 1ns / 1ps

module ndcg_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ndcg_pkg::cmd_t                      cmd,
    output ndcg_pkg::stat_t                     stat,
    input  logic                                op,
    input  logic signed [ndcg_pkg::SCORE_W-1:0] score,
    input  logic [ndcg_pkg::GRADE_W-1:0]        grade,
    input  logic [ndcg_pkg::DOC_AW-1:0]         first_doc,
    input  logic [ndcg_pkg::DOC_AW-1:0]         second_doc,
    output logic                                strobe,
    output logic                                kind,
    output logic signed [ndcg_pkg::VAL_W-1:0]   value,
    output logic                                error
);
    import ndcg_pkg::*;

    // Document stores.
    logic [SCORE_W-1:0] score_mem [NUM_DOCS];
    logic [GRADE_W-1:0] grade_mem [NUM_DOCS];
    logic [DOC_AW-1:0]  rank_mem  [NUM_DOCS];
    logic [SCORE_W-1:0] score_rd_reg;
    logic [GRADE_W-1:0] grade_rd_reg;
    logic [DOC_AW-1:0]  rank_rd_reg;

    // Query state.
    logic [CNT_W-1:0]   count_reg;
    logic               ready_reg;
    logic               lost_reg;
    logic [DCG_W-1:0]   ideal_reg;
    logic [DOC_AW-1:0]  a_reg;
    logic [DOC_AW-1:0]  b_reg;
    logic               kind_reg;
    logic               early_reg;

    // Sweep counters.
    logic [DOC_AW-1:0]  i_reg;
    logic [DOC_AW-1:0]  j_reg;
    logic [SCORE_W-1:0] key_reg;
    logic [DOC_AW-1:0]  rcnt_reg;
    logic               cmpv_reg;
    logic [DOC_AW-1:0]  cmpj_reg;
    logic               memv_reg;

    // Grade histogram and ideal ordering walk.
    logic [CNT_W-1:0]   hist_reg [MAX_GRADE+1];
    logic [GRADE_W-1:0] g_reg;
    logic [CNT_W-1:0]   gcnt_reg;
    logic [DOC_AW-1:0]  pos_reg;

    // Term multiplier and accumulators.
    logic [TERM_W-1:0]  prod_reg;
    logic               prodv_reg;
    acc_tgt_t           tgt_reg;
    logic [DCG_W-1:0]   dcg_reg;
    logic [PAIR_W-1:0]  neg_reg;
    logic [PAIR_W-1:0]  pos_sum_reg;
    logic [GRADE_W-1:0] ga_reg;
    logic [GRADE_W-1:0] gb_reg;
    logic [DOC_AW-1:0]  ra_reg;
    logic [DOC_AW-1:0]  rb_reg;
    logic [PAIR_W-1:0]  mag_reg;
    logic               sign_reg;

    // Divider.
    logic [REM_W-1:0]   rem_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic               sat_reg;
    logic [STEP_W-1:0]  dcnt_reg;

    // Result word.
    logic               strobe_reg;
    logic               kind_out_reg;
    logic [VAL_W-1:0]   value_reg;
    logic               error_reg;

    logic               load_acc;
    logic [DOC_AW-1:0]  wr_idx;
    logic               room;
    logic [DOC_AW-1:0]  rd_addr;
    logic               greater;
    logic               id_mul;
    logic               mul_go;
    logic [GRADE_W-1:0] mul_g;
    logic [DOC_AW-1:0]  mul_r;
    acc_tgt_t           mul_t;
    logic [GAIN_W-1:0]  gain;
    logic [REM_W-1:0]   num;
    logic [REM_W:0]     rem_sh;
    logic [REM_W:0]     den_ext;
    logic [DISC_W-1:0]  qv;
    logic               zero_out;

    // Load addressing: a closed query is replaced by the new load.
    assign load_acc = cmd.accept && (op == OP_LOAD);
    assign wr_idx   = ready_reg ? '0 : count_reg[DOC_AW-1:0];
    assign room     = ready_reg || (count_reg < CNT_W'(NUM_DOCS));

    // Shared read address of the stores.
    always_comb
    begin
        case (cmd.addr_sel)
            ADR_I:   rd_addr = i_reg;
            ADR_J:   rd_addr = j_reg;
            ADR_A:   rd_addr = a_reg;
            ADR_B:   rd_addr = b_reg;
            default: rd_addr = i_reg;
        endcase
    end

    // Store writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (load_acc && room)
        begin
            score_mem[wr_idx] <= score;
            grade_mem[wr_idx] <= grade;
        end
        if (cmd.rank_wr)
        begin
            rank_mem[i_reg] <= rcnt_reg;
        end
        score_rd_reg <= score_mem[rd_addr];
        grade_rd_reg <= grade_mem[rd_addr];
        rank_rd_reg  <= rank_mem[rd_addr];
    end

    // Ranking compare: higher score, or equal score at lower index.
    assign greater = ($signed(score_rd_reg) > $signed(key_reg)) ||
                     ((score_rd_reg == key_reg) && (cmpj_reg < i_reg));

    // Multiplier operand selection.
    assign id_mul = cmd.id_step && stat.hist_more;
    assign mul_go = id_mul || cmd.mul_en || memv_reg;
    always_comb
    begin
        mul_g = ga_reg;
        mul_r = ra_reg;
        mul_t = cmd.mul_tgt;
        if (memv_reg)
        begin
            mul_g = grade_rd_reg;
            mul_r = rank_rd_reg;
            mul_t = TGT_DCG;
        end
        else if (id_mul)
        begin
            mul_g = g_reg;
            mul_r = pos_reg;
            mul_t = TGT_IDEAL;
        end
        else
        begin
            case (cmd.mul_src)
                SRC_AA:
                begin
                    mul_g = ga_reg;
                    mul_r = ra_reg;
                end
                SRC_BB:
                begin
                    mul_g = gb_reg;
                    mul_r = rb_reg;
                end
                SRC_AB:
                begin
                    mul_g = ga_reg;
                    mul_r = rb_reg;
                end
                SRC_BA:
                begin
                    mul_g = gb_reg;
                    mul_r = ra_reg;
                end
                default:
                begin
                    mul_g = ga_reg;
                    mul_r = ra_reg;
                end
            endcase
        end
    end
    assign gain = GAIN_W'((GAIN_W+1)'(1) << mul_g) - GAIN_W'(1);

    // Division operands.
    assign num     = kind_reg ? REM_W'(mag_reg) : REM_W'(dcg_reg);
    assign rem_sh  = {rem_reg, 1'b0};
    assign den_ext = (REM_W+1)'(ideal_reg);

    // Status.
    assign stat.early_err = !ready_reg ||
                            (CNT_W'(first_doc) >= count_reg) ||
                            (CNT_W'(second_doc) >= count_reg) ||
                            (ideal_reg == '0);
    assign stat.j_last    = (CNT_W'(j_reg) == count_reg - CNT_W'(1));
    assign stat.i_last    = (CNT_W'(i_reg) == count_reg - CNT_W'(1));
    assign stat.hist_more = (gcnt_reg < hist_reg[g_reg]);
    assign stat.g_zero    = (g_reg == '0);
    assign stat.div_last  = (dcnt_reg == STEP_W'(DIV_STEPS - 1));

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ready_reg  <= 1'b0;
            lost_reg   <= 1'b0;
            ideal_reg  <= '0;
            cmpv_reg   <= 1'b0;
            memv_reg   <= 1'b0;
            prodv_reg  <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            cmpv_reg   <= cmd.sweep;
            memv_reg   <= cmd.dc_step;
            prodv_reg  <= mul_go;
            strobe_reg <= cmd.emit;
            if (load_acc)
            begin
                ready_reg <= 1'b0;
                if (room)
                begin
                    count_reg <= CNT_W'(wr_idx) + CNT_W'(1);
                end
                lost_reg <= ready_reg ? !room : (lost_reg || !room);
            end
            if (cmd.dc_init)
            begin
                ready_reg <= 1'b1;
            end
            if (cmd.id_init)
            begin
                ideal_reg <= '0;
            end
            else if (prodv_reg && (tgt_reg == TGT_IDEAL))
            begin
                ideal_reg <= ideal_reg + DCG_W'(prod_reg);
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            a_reg     <= first_doc;
            b_reg     <= second_doc;
            kind_reg  <= op;
            early_reg <= (op == OP_DELTA) && stat.early_err;
            sign_reg  <= 1'b0;
        end
        if (cmd.close_init)
        begin
            i_reg <= '0;
            for (int k = 0; k <= MAX_GRADE; k++)
            begin
                hist_reg[k] <= '0;
            end
        end
        if (cmd.rk_clr)
        begin
            j_reg    <= '0;
            rcnt_reg <= '0;
        end
        if (cmd.key_ld)
        begin
            key_reg <= score_rd_reg;
            for (int k = 0; k <= MAX_GRADE; k++)
            begin
                if (grade_rd_reg == GRADE_W'(k))
                begin
                    hist_reg[k] <= hist_reg[k] + CNT_W'(1);
                end
            end
        end
        if (cmd.sweep)
        begin
            j_reg    <= j_reg + DOC_AW'(1);
            cmpj_reg <= j_reg;
        end
        if (cmpv_reg && greater)
        begin
            rcnt_reg <= rcnt_reg + DOC_AW'(1);
        end
        if (cmd.rank_wr || cmd.dc_step)
        begin
            i_reg <= i_reg + DOC_AW'(1);
        end
        if (cmd.dc_init)
        begin
            i_reg   <= '0;
            dcg_reg <= '0;
        end
        // Ideal ordering: grades from high to low, ranks from zero up.
        if (cmd.id_init)
        begin
            g_reg    <= GRADE_W'(MAX_GRADE);
            gcnt_reg <= '0;
            pos_reg  <= '0;
        end
        else if (cmd.id_step)
        begin
            if (stat.hist_more)
            begin
                gcnt_reg <= gcnt_reg + CNT_W'(1);
                pos_reg  <= pos_reg + DOC_AW'(1);
            end
            else
            begin
                g_reg    <= g_reg - GRADE_W'(1);
                gcnt_reg <= '0;
            end
        end
        // One term per cycle while mul_go is high: gain times discount.
        if (mul_go)
        begin
            prod_reg <= TERM_W'(gain) * TERM_W'(DISC_TAB[mul_r]);
            tgt_reg  <= mul_t;
        end
        if (cmd.lat_a)
        begin
            ga_reg      <= grade_rd_reg;
            ra_reg      <= rank_rd_reg;
            neg_reg     <= '0;
            pos_sum_reg <= '0;
        end
        if (cmd.lat_b)
        begin
            gb_reg <= grade_rd_reg;
            rb_reg <= rank_rd_reg;
        end
        if (prodv_reg)
        begin
            case (tgt_reg)
                TGT_DCG: dcg_reg     <= dcg_reg + DCG_W'(prod_reg);
                TGT_NEG: neg_reg     <= neg_reg + PAIR_W'(prod_reg);
                TGT_POS: pos_sum_reg <= pos_sum_reg + PAIR_W'(prod_reg);
                default: dcg_reg     <= dcg_reg;
            endcase
        end
        if (cmd.mag_ld)
        begin
            sign_reg <= (neg_reg > pos_sum_reg);
            mag_reg  <= (neg_reg > pos_sum_reg) ? (neg_reg - pos_sum_reg)
                                                : (pos_sum_reg - neg_reg);
        end
        // Restoring division, one quotient bit per cycle.
        if (cmd.div_setup)
        begin
            rem_reg  <= num;
            quo_reg  <= '0;
            sat_reg  <= ((REM_W+1)'(num) >= den_ext);
            dcnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + STEP_W'(1);
            if (rem_sh >= den_ext)
            begin
                rem_reg <= REM_W'(rem_sh - den_ext);
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= REM_W'(rem_sh);
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
        if (cmd.emit)
        begin
            kind_out_reg <= kind_reg;
            error_reg    <= zero_out || lost_reg;
            if (zero_out)
            begin
                value_reg <= '0;
            end
            else if (sign_reg)
            begin
                value_reg <= VAL_W'(0) - VAL_W'(qv);
            end
            else
            begin
                value_reg <= VAL_W'(qv);
            end
        end
    end

    // Saturated quotient and the zero-result cases.
    assign qv       = sat_reg ? DISC_W'(1 << QUO_W) : DISC_W'(quo_reg);
    assign zero_out = early_reg || (ideal_reg == '0);

    assign strobe = strobe_reg;
    assign kind   = kind_out_reg;
    assign value  = $signed(value_reg);
    assign error  = error_reg;

endmodule

// ===== rtl/ndcg_swap_delta_engine_unit.sv =====
`timescale 1ns / 1ps

// NDCG swap-delta engine. A word is taken when start is high and busy is low.
// A load (op 0) leaves busy low, unless it carries last_doc: then the query
// closes and holds busy, mostly for the ranking pass that compares every
// document against every other through one store read port.
// The strobe carrying the NDCG follows in the next cycle. A delta query (op 1)
// spends most of its time to the strobe in the 16-step divider; an invalid one
// goes straight to the finishing state. Each result is shown for one cycle on
// strobe, kind, value and error, and there is no way to hold it off, so the
// receiver must sample every strobe.

module ndcg_swap_delta_engine_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                op,
    input  logic signed [ndcg_pkg::SCORE_W-1:0] score,
    input  logic [ndcg_pkg::GRADE_W-1:0]        grade,
    input  logic                                last_doc,
    input  logic [ndcg_pkg::DOC_AW-1:0]         first_doc,
    input  logic [ndcg_pkg::DOC_AW-1:0]         second_doc,
    output logic                                strobe,
    output logic                                kind,
    output logic signed [ndcg_pkg::VAL_W-1:0]   value,
    output logic                                error
);
    import ndcg_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer.
    ndcg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .op       (op),
        .last_doc (last_doc),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    // Stores, arithmetic and result word.
    ndcg_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .op         (op),
        .score      (score),
        .grade      (grade),
        .first_doc  (first_doc),
        .second_doc (second_doc),
        .strobe     (strobe),
        .kind       (kind),
        .value      (value),
        .error      (error)
    );

endmodule

// ===== rtl/ndcg_chk.sv =====
`timescale 1ns / 1ps

module ndcg_chk
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                op,
    input logic                                last_doc,
    input logic                                strobe,
    input logic                                kind,
    input logic signed [ndcg_pkg::VAL_W-1:0]   value
);
    import ndcg_pkg::*;

    // A result word never lasts more than one cycle.
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("strobe held for two cycles");

    // A result is only shown once the block is free again.
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !busy)
        else $error("strobe while busy");

    // A delta query always occupies the block.
    a_delta_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_DELTA)) |=> busy)
        else $error("delta query did not start work");

    // A plain load produces nothing and stays free.
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_LOAD) && !last_doc) |=> (!busy && !strobe))
        else $error("plain load produced activity");

    // An NDCG result is never negative.
    a_ndcg_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (kind == KIND_NDCG)) |-> (value >= 0))
        else $error("negative NDCG");

endmodule

bind ndcg_swap_delta_engine_unit ndcg_chk u_ndcg_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .op       (op),
    .last_doc (last_doc),
    .strobe   (strobe),
    .kind     (kind),
    .value    (value)
);

// ===== test/ndcg_swap_delta_engine_unit_tb.sv =====
`timescale 1ns / 1ps

module ndcg_swap_delta_engine_unit_tb;

    import ndcg_pkg::*;

    // One result word as it leaves the block.
    typedef struct {
        logic                    kind;
        logic signed [VAL_W-1:0] value;
        logic                    error;
    } ndcg_word_t;

    // One row of the directed stimulus; the result is typed in only where known.
    typedef struct {
        logic               op;
        logic [SCORE_W-1:0] score;
        logic [GRADE_W-1:0] grade;
        logic               last_doc;
        logic [DOC_AW-1:0]  first_doc;
        logic [DOC_AW-1:0]  second_doc;
        bit                 typed;
        ndcg_word_t         want;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic                       op = OP_LOAD;
    logic signed [SCORE_W-1:0]  score = '0;
    logic [GRADE_W-1:0]         grade = '0;
    logic                       last_doc = 1'b0;
    logic [DOC_AW-1:0]          first_doc = '0;
    logic [DOC_AW-1:0]          second_doc = '0;
    logic                       strobe;
    logic                       kind;
    logic signed [VAL_W-1:0]    value;
    logic                       error;

    // Shadow copy of the query store and its derived values.
    logic [SCORE_W-1:0] shadow_score [NUM_DOCS];
    logic [GRADE_W-1:0] shadow_grade [NUM_DOCS];
    int unsigned        shadow_rank [NUM_DOCS];
    int unsigned        shadow_count;
    longint unsigned    shadow_ideal;
    bit                 shadow_ready;
    bit                 shadow_lost;
    longint unsigned    discount_of [NUM_DOCS];

    ndcg_word_t pending_results [$];
    int         mismatches;
    int         words_loaded;
    int         words_delta;
    int         results_seen;
    int         queries_closed;

    ndcg_swap_delta_engine_unit DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .score      (score),
        .grade      (grade),
        .last_doc   (last_doc),
        .first_doc  (first_doc),
        .second_doc (second_doc),
        .strobe     (strobe),
        .kind       (kind),
        .value      (value),
        .error      (error)
    );

    // Clock of 8 ns.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Discount 2^16 / log2(rank + 2) from a 24-bit fractional logarithm, rounded.
    function automatic longint unsigned log_discount(input int unsigned rank);
        longint unsigned n;
        longint unsigned m;
        longint unsigned frac;
        longint unsigned l;
        int unsigned     k;
        n = rank + 2;
        k = 0;
        frac = 0;
        while ((n >> (k + 1)) != 0)
        begin
            k++;
        end
        m = n << (30 - k);
        for (int b = 0; b < 24; b++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        l = (longint'(k) << 24) | frac;
        return ((64'd1 << 40) + (l >> 1)) / l;
    endfunction

    function automatic longint unsigned dcg_term(input int unsigned g, input int unsigned rank);
        return ((64'd1 << g) - 1) * discount_of[rank];
    endfunction

    // Fraction num / den in Q1.16, truncated and capped at one.
    function automatic longint unsigned q16_fraction(input longint unsigned num,
                                                     input longint unsigned den);
        longint unsigned q;
        if (num >= den)
        begin
            return 65536;
        end
        q = (num << 16) / den;
        return (q > 65536) ? 65536 : q;
    endfunction

    // Rank the stored scores and sum the ideal DCG over the grades in descending order.
    task automatic close_query();
        int unsigned     hist [MAX_GRADE+1];
        int unsigned     pos;
        longint unsigned ki;
        longint unsigned kj;
        pos = 0;
        foreach (hist[g])
        begin
            hist[g] = 0;
        end
        for (int i = 0; i < shadow_count; i++)
        begin
            ki = shadow_score[i] ^ 32'h8000_0000;
            shadow_rank[i] = 0;
            for (int j = 0; j < shadow_count; j++)
            begin
                kj = shadow_score[j] ^ 32'h8000_0000;
                if (kj > ki || (kj == ki && j < i))
                begin
                    shadow_rank[i]++;
                end
            end
            hist[shadow_grade[i]]++;
        end
        shadow_ideal = 0;
        for (int g = MAX_GRADE; g >= 0; g--)
        begin
            for (int j = 0; j < hist[g]; j++)
            begin
                shadow_ideal += dcg_term(g, pos);
                pos++;
            end
        end
        shadow_ready = 1'b1;
        queries_closed++;
    endtask

    // Work out the result an accepted word causes, if any, and update the shadow state.
    task automatic ndcg_predict(input logic w_op, input logic [SCORE_W-1:0] w_score,
                                input logic [GRADE_W-1:0] w_grade, input logic w_last,
                                input int unsigned a, input int unsigned b,
                                output bit has_result, output ndcg_word_t r);
        longint unsigned dcg;
        longint unsigned lose;
        longint unsigned win;
        longint unsigned mag;
        has_result = 1'b0;
        r.kind = KIND_NDCG;
        r.value = '0;
        r.error = 1'b0;
        if (w_op == OP_LOAD)
        begin
            words_loaded++;
            if (shadow_ready)
            begin
                shadow_ready = 1'b0;
                shadow_count = 0;
                shadow_lost = 1'b0;
            end
            if (shadow_count < NUM_DOCS)
            begin
                shadow_score[shadow_count] = w_score;
                shadow_grade[shadow_count] = (w_grade > MAX_GRADE) ? GRADE_W'(MAX_GRADE)
                                                                   : w_grade;
                shadow_count++;
            end
            else
            begin
                shadow_lost = 1'b1;
            end
            if (!w_last)
            begin
                return;
            end
            close_query();
            dcg = 0;
            for (int i = 0; i < shadow_count; i++)
            begin
                dcg += dcg_term(shadow_grade[i], shadow_rank[i]);
            end
            has_result = 1'b1;
            if (shadow_ideal == 0)
            begin
                r.error = 1'b1;
            end
            else
            begin
                r.value = VAL_W'(q16_fraction(dcg, shadow_ideal));
                r.error = shadow_lost;
            end
        end
        else
        begin
            words_delta++;
            has_result = 1'b1;
            r.kind = KIND_DELTA;
            if (!shadow_ready || a >= shadow_count || b >= shadow_count || shadow_ideal == 0)
            begin
                r.error = 1'b1;
                return;
            end
            lose = dcg_term(shadow_grade[a], shadow_rank[a])
                 + dcg_term(shadow_grade[b], shadow_rank[b]);
            win  = dcg_term(shadow_grade[a], shadow_rank[b])
                 + dcg_term(shadow_grade[b], shadow_rank[a]);
            mag = (lose > win) ? lose - win : win - lose;
            mag = q16_fraction(mag, shadow_ideal);
            r.value = (lose > win) ? -VAL_W'(mag) : VAL_W'(mag);
            r.error = shadow_lost;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Every strobe is compared with the oldest expectation.
    always @(posedge clk)
    begin
        ndcg_word_t want;
        if (rst_n && strobe)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result word, kind", kind, -1);
            end
            else
            begin
                want = pending_results.pop_front();
                if (kind !== want.kind)
                begin
                    report_mismatch("kind", kind, want.kind);
                end
                if (value !== want.value)
                begin
                    report_mismatch("value", value, want.value);
                end
                if (error !== want.error)
                begin
                    report_mismatch("error", error, want.error);
                end
            end
        end
    end

    // Present one word and hold it until the block takes it.
    task automatic send_word(input logic w_op, input logic [SCORE_W-1:0] w_score,
                             input logic [GRADE_W-1:0] w_grade, input logic w_last,
                             input logic [DOC_AW-1:0] a, input logic [DOC_AW-1:0] b,
                             input bit typed, input ndcg_word_t want);
        bit         has_result;
        ndcg_word_t r;
        op         <= w_op;
        score      <= w_score;
        grade      <= w_grade;
        last_doc   <= w_last;
        first_doc  <= a;
        second_doc <= b;
        start      <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        ndcg_predict(w_op, w_score, w_grade, w_last, a, b, has_result, r);
        if (has_result)
        begin
            pending_results.push_back(typed ? want : r);
        end
    endtask

    // Mostly short gaps, now and then a long one; none while bursting.
    task automatic idle_gap(input bit burst);
        int n;
        n = 0;
        if (!burst)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: n = 0;
                5, 6, 7:       n = $urandom_range(1, 3);
                default:       n = $urandom_range(5, 40);
            endcase
        end
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [SCORE_W-1:0] pick_score();
        case ($urandom_range(3))
            0:       return SCORE_W'($urandom_range(3)) - 1;
            1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_load(input logic [SCORE_W-1:0] s, input logic [GRADE_W-1:0] g,
                             input logic l, input bit burst);
        ndcg_word_t none;
        none = '{KIND_NDCG, '0, 1'b0};
        send_word(OP_LOAD, s, g, l, '0, '0, 1'b0, none);
        idle_gap(burst);
    endtask

    task automatic send_delta(input logic [DOC_AW-1:0] a, input logic [DOC_AW-1:0] b,
                              input bit burst);
        ndcg_word_t none;
        none = '{KIND_NDCG, '0, 1'b0};
        send_word(OP_DELTA, SCORE_W'($urandom), GRADE_W'($urandom), 1'($urandom),
                  a, b, 1'b0, none);
        idle_gap(burst);
    endtask

    // Directed rows first, then random queries.
    initial
    begin
        stim_row_t  rows [$];
        ndcg_word_t none;
        int         docs;
        int         zero_grades;
        int         query_no;
        bit         burst;
        none = '{KIND_NDCG, '0, 1'b0};
        mismatches = 0;
        words_loaded = 0;
        words_delta = 0;
        results_seen = 0;
        queries_closed = 0;
        shadow_count = 0;
        shadow_ideal = 0;
        shadow_ready = 1'b0;
        shadow_lost = 1'b0;
        for (int i = 0; i < NUM_DOCS; i++)
        begin
            discount_of[i] = log_discount(i);
        end

        // Delta before any query, single-document queries, ties and score extremes.
        rows.push_back('{OP_DELTA, '0, '0, 1'b0, 8'd0, 8'd1, 1'b1, '{KIND_DELTA, '0, 1'b1}});
        rows.push_back('{OP_LOAD, 32'h7FFF_FFFF, 4'd15, 1'b1, '0, '0, 1'b1,
                         '{KIND_NDCG, 18'sd65536, 1'b0}});
        rows.push_back('{OP_DELTA, '0, '0, 1'b0, 8'd0, 8'd0, 1'b1, '{KIND_DELTA, '0, 1'b0}});
        rows.push_back('{OP_DELTA, '0, '0, 1'b0, 8'd0, 8'd1, 1'b1, '{KIND_DELTA, '0, 1'b1}});
        rows.push_back('{OP_LOAD, 32'h8000_0000, 4'd0, 1'b1, '0, '0, 1'b1,
                         '{KIND_NDCG, '0, 1'b1}});
        rows.push_back('{OP_DELTA, '0, '0, 1'b0, 8'd0, 8'd0, 1'b1, '{KIND_DELTA, '0, 1'b1}});
        rows.push_back('{OP_LOAD, 32'h0000_0000, 4'd3, 1'b0, '0, '0, 1'b0, none});
        rows.push_back('{OP_DELTA, '0, '0, 1'b0, 8'd0, 8'd0, 1'b1, '{KIND_DELTA, '0, 1'b1}});
        rows.push_back('{OP_LOAD, 32'h0000_0000, 4'd9, 1'b0, '0, '0, 1'b0, none});
        rows.push_back('{OP_LOAD, 32'hFFFF_FFFF, 4'd15, 1'b0, '0, '0, 1'b0, none});
        rows.push_back('{OP_LOAD, 32'h7FFF_FFFF, 4'd0, 1'b0, '0, '0, 1'b0, none});
        rows.push_back('{OP_LOAD, 32'h8000_0000, 4'd1, 1'b1, '0, '0, 1'b0, none});
        rows.push_back('{OP_DELTA, '0, '0, 1'b0, 8'd0, 8'd1, 1'b0, none});
        rows.push_back('{OP_DELTA, '0, '0, 1'b0, 8'd2, 8'd3, 1'b0, none});
        rows.push_back('{OP_DELTA, '0, '0, 1'b0, 8'd4, 8'd0, 1'b0, none});
        rows.push_back('{OP_DELTA, '0, '0, 1'b0, 8'd1, 8'd4, 1'b0, none});
        rows.push_back('{OP_DELTA, '0, '0, 1'b0, 8'd3, 8'd3, 1'b0, none});
        rows.push_back('{OP_DELTA, '0, '0, 1'b0, 8'd255, 8'd0, 1'b1, '{KIND_DELTA, '0, 1'b1}});
        rows.push_back('{OP_DELTA, '0, '0, 1'b0, 8'd0, 8'd5, 1'b1, '{KIND_DELTA, '0, 1'b1}});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_word(rows[i].op, rows[i].score, rows[i].grade, rows[i].last_doc,
                      rows[i].first_doc, rows[i].second_doc, rows[i].typed, rows[i].want);
            idle_gap(1'b0);
        end

        // Random queries: mostly small, one that overflows the store, rare large ones.
        query_no = 0;
        while (words_loaded + words_delta < 900)
        begin
            burst = ($urandom_range(4) == 0);
            if (query_no == 4)
            begin
                docs = NUM_DOCS + $urandom_range(1, 3);
            end
            else if ($urandom_range(99) == 0)
            begin
                docs = $urandom_range(100, NUM_DOCS);
            end
            else
            begin
                docs = $urandom_range(1, 12);
            end
            zero_grades = ($urandom_range(9) == 0);
            for (int d = 0; d < docs; d++)
            begin
                if ($urandom_range(29) == 0)
                begin
                    send_delta(DOC_AW'($urandom), DOC_AW'($urandom), burst);
                end
                send_load(pick_score(), zero_grades ? 4'd0 : GRADE_W'($urandom),
                          d == docs - 1, burst);
            end
            repeat ($urandom_range(0, 6))
            begin
                if ($urandom_range(7) == 0)
                begin
                    send_delta(DOC_AW'($urandom), DOC_AW'($urandom), burst);
                end
                else
                begin
                    send_delta(DOC_AW'($urandom_range(shadow_count - 1)),
                               DOC_AW'($urandom_range(shadow_count - 1)), burst);
                end
            end
            query_no++;
        end
        start <= 1'b0;

        // Drain and let the block settle.
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);

        $display("Covered %0d loads and %0d delta queries over %0d closed queries.",
                 words_loaded, words_delta, queries_closed);
        $display("Checked %0d result words, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #20ms;
        $display("Timeout with %0d results outstanding.", pending_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ndcg_pkg.sv
rtl/ndcg_ctrl.sv
rtl/ndcg_dp.sv
rtl/ndcg_swap_delta_engine_unit.sv
rtl/ndcg_chk.sv
test/ndcg_swap_delta_engine_unit_tb.sv
